>>> rtl/ate_pkg.sv
// shared types and codes for the alert table engine
package ate_pkg;

   typedef enum logic [2:0] {
      ACT_RAISE   = 3'd0,
      ACT_CLEAR   = 3'd1,
      ACT_ACK_ID  = 3'd2,
      ACT_ACK_SRC = 3'd3,
      ACT_PURGE   = 3'd4,
      ACT_READ    = 3'd5,
      ACT_MASK    = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_DUP        = 3'd2,
      STAT_NOT_FOUND  = 3'd3,
      STAT_SLOT_EMPTY = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_ROTATE,
      FSM_COMPACT,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] source;
      logic [3:0] alert_type;
      logic [1:0] priority_req;
      logic [7:0] ack_ident;
      logic [3:0] slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  assigned_id;
      logic [2:0]  entry_source;
      logic [3:0]  entry_type;
      logic [1:0]  entry_priority;
      logic [7:0]  entry_ident;
      logic        entry_acked;
      logic        entry_active;
      logic [15:0] type_mask;
      logic [4:0]  used_count;
      logic [4:0]  pending_count;
   } rsp_type;

   typedef struct packed {
      logic [2:0] src;
      logic [3:0] kind;
      logic [1:0] prio;
      logic [7:0] ident;
      logic       acked;
      logic       active;
   } alert_entry_type;

   // drop marks a hole to be squeezed out by compaction
   typedef struct packed {
      alert_entry_type entry;
      logic            drop;
   } cell_data_type;

   typedef struct packed {
      logic rotate;
      logic swap_lo;
      logic swap_hi;
      logic write;
   } cell_ctl_type;

   typedef struct packed {
      logic evicted;
      logic dup;
      logic found;
   } head_flag_type;

endpackage

>>> rtl/ate_cell.sv
// one table position: holds an entry and trades it with its neighbours
module ate_cell (
   input  logic                  clock,
   input  ate_pkg::cell_ctl_type  ctl,
   input  ate_pkg::cell_data_type left_in,
   input  ate_pkg::cell_data_type right_in,
   input  ate_pkg::cell_data_type wr_data,
   output ate_pkg::cell_data_type data_out
);

   ate_pkg::cell_data_type data_ff;
   ate_pkg::cell_data_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.write) begin
         data_in = wr_data;
      end else if (ctl.rotate) begin
         data_in = right_in;
      end else if (ctl.swap_lo && data_ff.drop && !right_in.drop) begin
         // hole moves up, upper entry moves down
         data_in = right_in;
      end else if (ctl.swap_hi && left_in.drop && !data_ff.drop) begin
         data_in = left_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

>>> rtl/ate_head.sv
// processing head: works on the entry leaving cell 0 during a rotation
module ate_head #(
   parameter  int TABLE_DEPTH = 16,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     step,
   input  ate_pkg::req_type         req,
   input  logic [IDX_W-1:0]         pos,
   input  logic [CNT_W-1:0]         count,
   input  ate_pkg::cell_data_type   cell_in,
   output ate_pkg::cell_data_type   cell_out,
   output ate_pkg::head_flag_type   flags,
   output logic [15:0]              mask,
   output logic [CNT_W-1:0]         pend,
   output logic [CNT_W-1:0]         removed,
   output ate_pkg::alert_entry_type rd_entry
);

   localparam int SEL_W = (CNT_W > 4) ? CNT_W : 4;

   ate_pkg::head_flag_type   flags_ff, flags_in;
   logic [15:0]              mask_ff, mask_in;
   logic [CNT_W-1:0]         pend_ff, pend_in;
   logic [CNT_W-1:0]         removed_ff, removed_in;
   ate_pkg::alert_entry_type rd_ff, rd_in;

   ate_pkg::alert_entry_type ent;
   logic                     drop;
   logic                     live;
   logic                     full;
   logic                     src_hit;
   logic                     kind_hit;

   assign live     = CNT_W'(pos) < count;
   assign full     = count == CNT_W'(TABLE_DEPTH);
   assign src_hit  = cell_in.entry.src == req.source;
   assign kind_hit = cell_in.entry.kind == req.alert_type;

   always_comb begin
      ent      = cell_in.entry;
      drop     = !live;
      flags_in = flags_ff;
      mask_in  = mask_ff;
      rd_in    = rd_ff;
      if (live) begin
         case (req.action)
            ate_pkg::ACT_RAISE: begin
               // full table: first acked entry goes, and is not a duplicate
               if (full && !flags_ff.evicted && ent.acked) begin
                  drop             = 1'b1;
                  flags_in.evicted = 1'b1;
               end else if (src_hit && kind_hit && ent.active) begin
                  flags_in.dup = 1'b1;
               end
            end
            ate_pkg::ACT_CLEAR: begin
               if (src_hit && kind_hit && ent.active) begin
                  ent.active = 1'b0;
               end
            end
            ate_pkg::ACT_ACK_ID: begin
               if (!flags_ff.found && ent.ident == req.ack_ident) begin
                  ent.acked      = 1'b1;
                  flags_in.found = 1'b1;
               end
            end
            ate_pkg::ACT_ACK_SRC: begin
               if (src_hit) begin
                  ent.acked = 1'b1;
               end
            end
            ate_pkg::ACT_PURGE: begin
               if (ent.acked && !ent.active) begin
                  drop = 1'b1;
               end
            end
            ate_pkg::ACT_READ: begin
               if (SEL_W'(pos) == SEL_W'(req.slot)) begin
                  rd_in = ent;
               end
            end
            ate_pkg::ACT_MASK: begin
               if (src_hit && ent.active) begin
                  mask_in = mask_ff | (16'd1 << ent.kind);
               end
            end
            default: begin
            end
         endcase
      end
      pend_in    = pend_ff + CNT_W'(live && !drop && ent.active && !ent.acked);
      removed_in = removed_ff + CNT_W'(live && drop);
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         flags_ff   <= '0;
         mask_ff    <= '0;
         pend_ff    <= '0;
         removed_ff <= '0;
      end else if (step) begin
         flags_ff   <= flags_in;
         mask_ff    <= mask_in;
         pend_ff    <= pend_in;
         removed_ff <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rd_ff <= rd_in;
      end
   end

   assign cell_out = '{entry: ent, drop: drop};
   assign flags    = flags_ff;
   assign mask     = mask_ff;
   assign pend     = pend_ff;
   assign removed  = removed_ff;
   assign rd_entry = rd_ff;

endmodule

>>> rtl/alert_table_engine.sv
// alert table engine top level: cell chain, processing head and sequencer
// a request is taken only while idle and passes one full rotation of the cell ring
//   past the head, a compaction pass when entries are removed (eviction on a full
//   raise, purge) and a finishing step that waits while the result is stalled;
//   the next request is taken only after the finishing step hands over the result
// reset: synchronous; empties the table, next id is 1, result register empty
module alert_table_engine #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ate_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ate_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SEL_W = (CNT_W > 4) ? CNT_W : 4;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_DEPTH - 1);

   // sequencer state
   ate_pkg::fsm_type  state_ff, state_in;
   ate_pkg::req_type  req_ff;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        ident_ff, ident_in;
   ate_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // chain wiring
   ate_pkg::cell_data_type cell_q   [TABLE_DEPTH];
   ate_pkg::cell_data_type left_nb  [TABLE_DEPTH];
   ate_pkg::cell_data_type right_nb [TABLE_DEPTH];
   ate_pkg::cell_ctl_type  cell_ctl [TABLE_DEPTH];
   ate_pkg::cell_data_type head_out;
   ate_pkg::cell_data_type wr_data;

   // head results
   ate_pkg::head_flag_type   flags;
   logic [15:0]              mask;
   logic [CNT_W-1:0]         pend;
   logic [CNT_W-1:0]         removed;
   ate_pkg::alert_entry_type rd_entry;

   // control
   logic             accept;
   logic             out_free;
   logic             rotate_en;
   logic             compact_en;
   logic             finish_fire;
   logic             append;
   logic [CNT_W-1:0] new_cnt;
   logic [CNT_W-1:0] cnt_after;

   assign req_stall = state_ff != ate_pkg::FSM_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ate_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = ate_pkg::FSM_ROTATE;
            end
         end
         ate_pkg::FSM_ROTATE: begin
            if (pos_ff == LAST_POS) begin
               state_in = ate_pkg::FSM_COMPACT;
            end
         end
         ate_pkg::FSM_COMPACT: begin
            // nothing removed: the table is already in order
            if (pos_ff == LAST_POS || removed == '0) begin
               state_in = ate_pkg::FSM_FINISH;
            end
         end
         ate_pkg::FSM_FINISH: begin
            if (out_free) begin
               state_in = ate_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = ate_pkg::FSM_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      rotate_en   = state_ff == ate_pkg::FSM_ROTATE;
      compact_en  = (state_ff == ate_pkg::FSM_COMPACT) && (removed != '0);
      finish_fire = (state_ff == ate_pkg::FSM_FINISH) && out_free;
      pos_in      = pos_ff;
      case (state_ff)
         ate_pkg::FSM_ROTATE: begin
            pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
         end
         ate_pkg::FSM_COMPACT: begin
            // one odd-even exchange round per cycle, parity from pos
            pos_in = pos_ff + 1'b1;
         end
         default: begin
            pos_in = '0;
         end
      endcase
   end

   // result and bookkeeping for the finishing cycle
   always_comb begin
      rsp_in    = '0;
      append    = 1'b0;
      new_cnt   = count_ff - removed;
      case (req_ff.action)
         ate_pkg::ACT_RAISE: begin
            if (count_ff == CNT_W'(TABLE_DEPTH) && !flags.evicted) begin
               rsp_in.status = ate_pkg::STAT_FULL;
            end else if (flags.dup) begin
               rsp_in.status = ate_pkg::STAT_DUP;
            end else begin
               append             = 1'b1;
               rsp_in.assigned_id = ident_ff;
            end
         end
         ate_pkg::ACT_ACK_ID: begin
            rsp_in.status = flags.found ? ate_pkg::STAT_OK : ate_pkg::STAT_NOT_FOUND;
         end
         ate_pkg::ACT_READ: begin
            if (SEL_W'(req_ff.slot) < SEL_W'(count_ff)) begin
               rsp_in.entry_source   = rd_entry.src;
               rsp_in.entry_type     = rd_entry.kind;
               rsp_in.entry_priority = rd_entry.prio;
               rsp_in.entry_ident    = rd_entry.ident;
               rsp_in.entry_acked    = rd_entry.acked;
               rsp_in.entry_active   = rd_entry.active;
            end else begin
               rsp_in.status = ate_pkg::STAT_SLOT_EMPTY;
            end
         end
         ate_pkg::ACT_MASK: begin
            rsp_in.type_mask = mask;
         end
         default: begin
         end
      endcase
      cnt_after            = new_cnt + CNT_W'(append);
      rsp_in.used_count    = 5'(cnt_after);
      rsp_in.pending_count = 5'(pend + CNT_W'(append));
   end

   always_comb begin
      count_in     = count_ff;
      ident_in     = ident_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish_fire) begin
         count_in     = cnt_after;
         ident_in     = ident_ff + 8'(append);
         rsp_valid_in = 1'b1;
      end
   end

   // new entry lands just above the compacted table
   assign wr_data = '{entry: '{src: req_ff.source, kind: req_ff.alert_type,
                               prio: req_ff.priority_req, ident: ident_ff,
                               acked: 1'b0, active: 1'b1},
                      drop: 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ate_pkg::FSM_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         ident_ff     <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         ident_ff     <= ident_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (finish_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // ring of cells: cell i takes cell i+1, the last cell takes the head output
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam logic IS_LAST  = (i == TABLE_DEPTH - 1);
      localparam logic IS_FIRST = (i == 0);
      localparam logic PAR_LO   = 1'(i % 2);
      localparam logic PAR_HI   = 1'((i + 1) % 2);

      if (IS_LAST) begin : g_right_head
         assign right_nb[i] = head_out;
      end else begin : g_right_cell
         assign right_nb[i] = cell_q[i+1];
      end

      if (IS_FIRST) begin : g_left_self
         assign left_nb[i] = cell_q[i];
      end else begin : g_left_cell
         assign left_nb[i] = cell_q[i-1];
      end

      // lower of a pair when its parity matches, upper when its neighbour's does
      assign cell_ctl[i].rotate  = rotate_en;
      assign cell_ctl[i].swap_lo = compact_en && !IS_LAST && (PAR_LO == pos_ff[0]);
      assign cell_ctl[i].swap_hi = compact_en && !IS_FIRST && (PAR_HI == pos_ff[0]);
      assign cell_ctl[i].write   = finish_fire && append && (new_cnt == CNT_W'(i));

      ate_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .left_in  (left_nb[i]),
         .right_in (right_nb[i]),
         .wr_data  (wr_data),
         .data_out (cell_q[i])
      );
   end

   ate_head #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_head (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .step     (rotate_en),
      .req      (req_ff),
      .pos      (pos_ff),
      .count    (count_ff),
      .cell_in  (cell_q[0]),
      .cell_out (head_out),
      .flags    (flags),
      .mask     (mask),
      .pend     (pend),
      .removed  (removed),
      .rd_entry (rd_entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/ate_checker.sv
// port-level checks for the alert table engine, bound to the top level
module ate_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ate_pkg::rsp_type rsp_data
);

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one request in flight: busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_pending_le_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TABLE_DEPTH > 31) ||
                    (rsp_data.pending_count <= rsp_data.used_count))
      else $error("pending count above used count");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ate_pkg::STAT_OK) |->
         (rsp_data.assigned_id == 8'd0) && (rsp_data.type_mask == 16'd0) &&
         (rsp_data.entry_ident == 8'd0))
      else $error("result fields set on an error status");

endmodule

bind alert_table_engine ate_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_ate_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> test/tb_alert_table_engine.sv
// self-checking testbench for the alert table engine
`timescale 1ns / 1ps

module tb_alert_table_engine;

   localparam int TABLE_DEPTH = 16;
   // the action field has one code that the block must accept and ignore
   localparam logic [2:0] ACT_UNUSED = 3'd7;
   // a request takes up to two passes of the ring, so this covers the drain
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
   localparam int IDLE_PERCENT = 32;
   localparam int HOLD_CYCLES = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ate_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ate_pkg::rsp_type rsp_data;

   alert_table_engine #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow copy of the alert table, updated as each request is accepted
   // ---------------------------------------------------------------------
   ate_pkg::alert_entry_type alert_table [TABLE_DEPTH];
   int                       table_used = 0;
   logic [7:0]               shadow_next_ident = 8'd1;
   bit                       ident_wrapped = 1'b0;

   // responses still owed by the block, oldest first
   ate_pkg::rsp_type         owed_responses [$];
   int                       err_count = 0;

   // random idling on both sides, and requests for a long receiver hold-off
   bit                       idle_enabled = 1'b0;
   int                       hold_requests = 0;

   // take one entry out and close the gap by shifting the later entries down
   function automatic void remove_entry(int pos);
      int k;
      for (k = pos; k + 1 < table_used; k++) begin
         alert_table[k] = alert_table[k + 1];
      end
      table_used--;
   endfunction

   // apply one request to the shadow table and return the response it owes
   function automatic ate_pkg::rsp_type apply_alert_request(ate_pkg::req_type rq);
      ate_pkg::rsp_type rs;
      int               k;
      int               w;
      bit               done;
      bit               dup;
      logic [15:0]      mask;
      int               pending;
      rs = '0;
      done = 1'b0;
      dup = 1'b0;
      mask = '0;
      pending = 0;
      case (rq.action)
         ate_pkg::ACT_RAISE: begin
            // a full table first gives up its oldest acknowledged entry,
            // even when the raise then turns out to be a duplicate
            if (table_used >= TABLE_DEPTH) begin
               for (k = 0; k < table_used; k++) begin
                  if (!done && alert_table[k].acked) begin
                     remove_entry(k);
                     done = 1'b1;
                  end
               end
            end
            if (table_used >= TABLE_DEPTH) begin
               rs.status = ate_pkg::STAT_FULL;
            end else begin
               for (k = 0; k < table_used; k++) begin
                  if (alert_table[k].src == rq.source &&
                      alert_table[k].kind == rq.alert_type &&
                      alert_table[k].active) begin
                     dup = 1'b1;
                  end
               end
               if (dup) begin
                  rs.status = ate_pkg::STAT_DUP;
               end else begin
                  alert_table[table_used].src    = rq.source;
                  alert_table[table_used].kind   = rq.alert_type;
                  alert_table[table_used].prio   = rq.priority_req;
                  alert_table[table_used].ident  = shadow_next_ident;
                  alert_table[table_used].acked  = 1'b0;
                  alert_table[table_used].active = 1'b1;
                  table_used++;
                  rs.assigned_id = shadow_next_ident;
                  if (shadow_next_ident == 8'hFF) begin
                     ident_wrapped = 1'b1;
                  end
                  shadow_next_ident = shadow_next_ident + 8'd1;
               end
            end
         end
         ate_pkg::ACT_CLEAR: begin
            for (k = 0; k < table_used; k++) begin
               if (alert_table[k].src == rq.source &&
                   alert_table[k].kind == rq.alert_type) begin
                  alert_table[k].active = 1'b0;
               end
            end
         end
         ate_pkg::ACT_ACK_ID: begin
            // only the first entry in table order carrying the id
            rs.status = ate_pkg::STAT_NOT_FOUND;
            for (k = 0; k < table_used; k++) begin
               if (!done && alert_table[k].ident == rq.ack_ident) begin
                  alert_table[k].acked = 1'b1;
                  rs.status = ate_pkg::STAT_OK;
                  done = 1'b1;
               end
            end
         end
         ate_pkg::ACT_ACK_SRC: begin
            for (k = 0; k < table_used; k++) begin
               if (alert_table[k].src == rq.source) begin
                  alert_table[k].acked = 1'b1;
               end
            end
         end
         ate_pkg::ACT_PURGE: begin
            // keep everything except entries both acknowledged and cleared
            w = 0;
            for (k = 0; k < table_used; k++) begin
               if (!alert_table[k].acked || alert_table[k].active) begin
                  alert_table[w] = alert_table[k];
                  w++;
               end
            end
            table_used = w;
         end
         ate_pkg::ACT_READ: begin
            if (int'(rq.slot) >= table_used) begin
               rs.status = ate_pkg::STAT_SLOT_EMPTY;
            end else begin
               rs.entry_source   = alert_table[rq.slot].src;
               rs.entry_type     = alert_table[rq.slot].kind;
               rs.entry_priority = alert_table[rq.slot].prio;
               rs.entry_ident    = alert_table[rq.slot].ident;
               rs.entry_acked    = alert_table[rq.slot].acked;
               rs.entry_active   = alert_table[rq.slot].active;
            end
         end
         ate_pkg::ACT_MASK: begin
            for (k = 0; k < table_used; k++) begin
               if (alert_table[k].src == rq.source && alert_table[k].active) begin
                  mask = mask | (16'd1 << alert_table[k].kind);
               end
            end
            rs.type_mask = mask;
         end
         default: begin
            // unused action code: no change, plain ok
         end
      endcase
      for (k = 0; k < table_used; k++) begin
         if (alert_table[k].active && !alert_table[k].acked) begin
            pending++;
         end
      end
      rs.used_count    = 5'(table_used);
      rs.pending_count = 5'(pending);
      return rs;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // offer one request, hold it until accepted, then maybe go quiet a while;
   // valid is only lowered when a gap follows, never dropped and re-raised
   task automatic send_request(input ate_pkg::req_type rq);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      owed_responses.push_back(apply_alert_request(rq));
      if (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic ate_pkg::req_type make_request(input logic [2:0] act,
                                                     input logic [2:0] src,
                                                     input logic [3:0] kind,
                                                     input logic [1:0] prio,
                                                     input logic [7:0] id,
                                                     input logic [3:0] slot);
      ate_pkg::req_type rq;
      rq.action       = act;
      rq.source       = src;
      rq.alert_type   = kind;
      rq.priority_req = prio;
      rq.ack_ident    = id;
      rq.slot         = slot;
      return rq;
   endfunction

   // random request, steered towards entries that are really in the table
   // so that clears, acknowledges and duplicates hit something
   function automatic ate_pkg::req_type random_request();
      ate_pkg::req_type rq;
      logic [31:0]      bits;
      int               pick;
      int               pos;
      bits = $urandom;
      rq = bits[23:0];
      pick = $urandom_range(99);
      pos = (table_used > 0) ? $urandom_range(table_used - 1) : 0;
      if (pick < 45) begin
         rq.action = ate_pkg::ACT_RAISE;
         if (table_used > 0 && $urandom_range(99) < 20) begin
            rq.source     = alert_table[pos].src;
            rq.alert_type = alert_table[pos].kind;
         end
      end else if (pick < 57) begin
         rq.action = ate_pkg::ACT_CLEAR;
         if (table_used > 0 && $urandom_range(99) < 60) begin
            rq.source     = alert_table[pos].src;
            rq.alert_type = alert_table[pos].kind;
         end
      end else if (pick < 67) begin
         rq.action = ate_pkg::ACT_ACK_ID;
         if (table_used > 0 && $urandom_range(99) < 70) begin
            rq.ack_ident = alert_table[pos].ident;
         end
      end else if (pick < 76) begin
         rq.action = ate_pkg::ACT_ACK_SRC;
      end else if (pick < 82) begin
         rq.action = ate_pkg::ACT_PURGE;
      end else if (pick < 90) begin
         rq.action = ate_pkg::ACT_READ;
         if (table_used > 0 && $urandom_range(99) < 80) begin
            rq.slot = 4'(pos);
         end
      end else if (pick < 97) begin
         rq.action = ate_pkg::ACT_MASK;
      end else begin
         rq.action = ACT_UNUSED;
      end
      return rq;
   endfunction

   // ---------------------------------------------------------------------
   // response side: stall pattern and checking in one clocked process
   // ---------------------------------------------------------------------
   int               hold_left = 0;
   int               holds_served = 0;
   ate_pkg::rsp_type want_rsp;

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // rsp_stall read here is still the value the block saw at this edge
         if (rsp_valid && !rsp_stall) begin
            if (owed_responses.size() == 0) begin
               $error("response with no request outstanding");
               err_count++;
            end else begin
               want_rsp = owed_responses.pop_front();
               check_field("status",         16'(want_rsp.status),         16'(rsp_data.status));
               check_field("assigned_id",    16'(want_rsp.assigned_id),
                           16'(rsp_data.assigned_id));
               check_field("entry_source",   16'(want_rsp.entry_source),
                           16'(rsp_data.entry_source));
               check_field("entry_type",     16'(want_rsp.entry_type),
                           16'(rsp_data.entry_type));
               check_field("entry_priority", 16'(want_rsp.entry_priority),
                           16'(rsp_data.entry_priority));
               check_field("entry_ident",    16'(want_rsp.entry_ident),
                           16'(rsp_data.entry_ident));
               check_field("entry_acked",    16'(want_rsp.entry_acked),
                           16'(rsp_data.entry_acked));
               check_field("entry_active",   16'(want_rsp.entry_active),
                           16'(rsp_data.entry_active));
               check_field("type_mask",      want_rsp.type_mask,           rsp_data.type_mask);
               check_field("used_count",     16'(want_rsp.used_count),
                           16'(rsp_data.used_count));
               check_field("pending_count",  16'(want_rsp.pending_count),
                           16'(rsp_data.pending_count));
            end
         end
         // a pending hold-off request starts a long, counted stall
         if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (idle_enabled) begin
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // empty-table answers, a first raise, duplicate, acks, clear and purge, reads, masks and an unused code
   task automatic test_basic_actions();
      send_request(make_request(ate_pkg::ACT_READ,    3'd0, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_MASK,    3'd7, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_ACK_ID,  3'd0, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_RAISE,   3'd0, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_RAISE,   3'd7, 4'd15, 2'd3, 8'd255, 4'd15));
      // same source and kind while still active: suppressed
      send_request(make_request(ate_pkg::ACT_RAISE,   3'd7, 4'd15, 2'd2, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_ACK_ID,  3'd0, 4'd0,  2'd0, 8'd2,   4'd0));
      send_request(make_request(ate_pkg::ACT_ACK_ID,  3'd7, 4'd15, 2'd3, 8'd255, 4'd15));
      send_request(make_request(ate_pkg::ACT_READ,    3'd0, 4'd0,  2'd0, 8'd0,   4'd1));
      send_request(make_request(ate_pkg::ACT_READ,    3'd0, 4'd0,  2'd0, 8'd0,   4'd15));
      send_request(make_request(ate_pkg::ACT_MASK,    3'd7, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_CLEAR,   3'd7, 4'd15, 2'd0, 8'd0,   4'd0));
      // acknowledged and cleared, so purge squeezes it out
      send_request(make_request(ate_pkg::ACT_PURGE,   3'd0, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ate_pkg::ACT_ACK_SRC, 3'd0, 4'd0,  2'd0, 8'd0,   4'd0));
      send_request(make_request(ACT_UNUSED,           3'd5, 4'd9,  2'd1, 8'd77,  4'd3));
   endtask

   // fill the table, then raise into it with and without acknowledged entries
   task automatic test_full_table();
      int k;
      k = 0;
      while (table_used < TABLE_DEPTH) begin
         send_request(make_request(ate_pkg::ACT_RAISE, 3'(k), 4'(4 + k / 8), 2'(k),
                                   8'd0, 4'd0));
         k++;
      end
      // evicts the one acknowledged entry, then has nothing left to evict
      send_request(make_request(ate_pkg::ACT_RAISE, 3'd3, 4'd9, 2'd1, 8'd0, 4'd0));
      send_request(make_request(ate_pkg::ACT_RAISE, 3'd4, 4'd9, 2'd1, 8'd0, 4'd0));
      send_request(make_request(ate_pkg::ACT_READ,  3'd0, 4'd0, 2'd0, 8'd0, 4'd15));
      // eviction still happens on a raise that is then a duplicate
      send_request(make_request(ate_pkg::ACT_ACK_ID, 3'd0, 4'd0, 2'd0,
                                alert_table[5].ident, 4'd0));
      send_request(make_request(ate_pkg::ACT_RAISE, alert_table[0].src,
                                alert_table[0].kind, 2'd0, 8'd0, 4'd0));
      send_request(make_request(ate_pkg::ACT_MASK,  3'd1, 4'd0, 2'd0, 8'd0, 4'd0));
   endtask

   // receiver holds off long enough for the block to back up into its input
   task automatic test_backpressure();
      int n;
      hold_requests++;
      for (n = 0; n < 12; n++) begin
         send_request(random_request());
      end
   endtask

   // random mix; optionally runs a little longer to let the alert id wrap
   task automatic test_random_mix(input int count, input bit until_wrap);
      int n;
      n = 0;
      while (n < count || (until_wrap && !ident_wrapped && n < count + 200)) begin
         send_request(random_request());
         n++;
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_actions();
      test_full_table();
      idle_enabled = 1'b1;
      test_backpressure();
      test_random_mix(250, 1'b0);
      // a stretch with no idling on either side
      idle_enabled = 1'b0;
      test_random_mix(150, 1'b0);
      idle_enabled = 1'b1;
      test_backpressure();
      test_random_mix(300, 1'b1);

      req_valid <= 1'b0;
      while (owed_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ate_pkg.sv
rtl/ate_cell.sv
rtl/ate_head.sv
rtl/alert_table_engine.sv
rtl/ate_checker.sv
test/tb_alert_table_engine.sv
